@@ rtl/smpq_pkg.sv @@
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants for the stable minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned MAX_BYTES = 1048576;

  localparam int unsigned PRIO_W  = 16;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned BYTES_W = 21;
  localparam int unsigned OCC_W   = 5;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSHED    = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_POPPED    = 2'd2,
    ST_POP_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [ID_W-1:0]    id;
    logic [BYTES_W-1:0] bytes;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

@@ rtl/smpq_cell.sv @@
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted chain. On a push it keeps its entry, takes the new
// entry, or takes its left neighbor's entry; on a pop it takes its right
// neighbor's entry.
// ----------------------------------------------------------------------------
module smpq_cell (
  input  logic               clk,
  input  smpq_pkg::cell_ctl_t ctl,
  input  logic               slot_valid,
  input  smpq_pkg::entry_t   new_entry,
  input  smpq_pkg::entry_t   left_entry,
  input  logic               left_go,
  input  smpq_pkg::entry_t   right_entry,
  output smpq_pkg::entry_t   entry,
  output logic               go
);
  import smpq_pkg::*;

  entry_t entry_r;

  // go: the new entry belongs at or before this slot
  assign go    = !slot_valid || (entry_r.prio > new_entry.prio);
  assign entry = entry_r;

  always_ff @(posedge clk) begin
    if (ctl.push && go) begin
      entry_r <= left_go ? left_entry : new_entry;
    end else if (ctl.pop) begin
      entry_r <= right_entry;
    end
  end

endmodule

@@ rtl/stable_min_priority_queue.sv @@
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// Sorted-list priority queue built as a chain of slot cells; lowest priority
// leaves first, equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction is a push
//   (in_operation = 0, carrying priority, work id and byte count) or a pop
//   (in_operation = 1, other fields ignored). Byte counts above MAX_BYTES
//   are saturated on push.
//   Result channel (out_valid / out_stall): exactly one transaction per input
//   transaction, in order, with status, the popped entry (zero unless
//   popped) and the occupancy after the operation.
//   out_valid rises the cycle after acceptance. While in_stall is low, one
//   item is taken per cycle; every slot cell compares against the new priority
//   and shifts in the same cycle, so the rate is set by that single compare.
//   A push to a full queue is dropped and reported; a pop on empty reports.
//   Reset empties the queue at once; there is no clearing pass.
//   While a result waits under out_stall, in_stall is raised and no further
//   transaction is taken until the result register is free.
// ----------------------------------------------------------------------------
module stable_min_priority_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [smpq_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic [smpq_pkg::ID_W-1:0]     in_work_id,
  input  logic [smpq_pkg::BYTES_W-1:0]  in_byte_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [smpq_pkg::PRIO_W-1:0]   out_priority,
  output logic [smpq_pkg::ID_W-1:0]     out_work_id,
  output logic [smpq_pkg::BYTES_W-1:0]  out_byte_count,
  output logic [smpq_pkg::OCC_W-1:0]    out_occupancy
);
  import smpq_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  entry_t           res_r, res_nxt;
  logic [OCC_W-1:0] occ_r;

  logic      accept, is_push, full, empty;
  cell_ctl_t ctl;
  entry_t    new_entry;
  entry_t    cell_entry [DEPTH];
  logic      cell_go    [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_push  = (in_operation == OP_PUSH);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  assign ctl.push = accept && is_push && !full;
  assign ctl.pop  = accept && !is_push && !empty;

  always_comb begin
    new_entry.prio  = in_priority_req;
    new_entry.id    = in_work_id;
    new_entry.bytes = (32'(in_byte_count) > MAX_BYTES) ? BYTES_W'(MAX_BYTES)
                                                      : in_byte_count;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    entry_t left_e, right_e;
    logic   left_g;

    if (i == 0) begin : g_first
      assign left_e = new_entry;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_g = cell_go[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = cell_entry[i];
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    smpq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .slot_valid  (IDX < count_r),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_go     (left_g),
      .right_entry (right_e),
      .entry       (cell_entry[i]),
      .go          (cell_go[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    res_nxt    = '0;
    status_nxt = ST_PUSHED;
    if (is_push) begin
      if (full) begin
        status_nxt = ST_DROPPED;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (empty) begin
        status_nxt = ST_POP_EMPTY;
      end else begin
        status_nxt = ST_POPPED;
        res_nxt    = cell_entry[0];
        count_nxt  = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_priority   = res_r.prio;
  assign out_work_id    = res_r.id;
  assign out_byte_count = res_r.bytes;
  assign out_occupancy  = occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |=> count_r == $past(count_r) + 1'b1)
    else $error("push did not grow the queue");

  a_pop_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_POP_EMPTY || status_r == ST_DROPPED))
      |-> (res_r == '0))
    else $error("non-pop result carries entry data");

  a_empty_pop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_push && empty) |=> count_r == '0)
    else $error("pop on empty changed count");

endmodule

@@ test/smpq_checker.sv @@
// ----------------------------------------------------------------------------
// smpq_checker
// Watches both channels of the stable minimum priority queue. It keeps its
// own sorted copy of the queue and builds the expected result for every
// accepted input transaction. It then compares each accepted result
// transaction, field by field, with the oldest expected result.
// ----------------------------------------------------------------------------
module smpq_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_operation,
  input  logic [smpq_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic [smpq_pkg::ID_W-1:0]     in_work_id,
  input  logic [smpq_pkg::BYTES_W-1:0]  in_byte_count,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [1:0]                    out_status,
  input  logic [smpq_pkg::PRIO_W-1:0]   out_priority,
  input  logic [smpq_pkg::ID_W-1:0]     out_work_id,
  input  logic [smpq_pkg::BYTES_W-1:0]  out_byte_count,
  input  logic [smpq_pkg::OCC_W-1:0]    out_occupancy,
  output int unsigned                   fail_count,
  output int unsigned                   pending,
  output int unsigned                   checked,
  output int unsigned                   drops,
  output int unsigned                   empty_pops
);
  import smpq_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [PRIO_W-1:0]  prio;
    logic [ID_W-1:0]    id;
    logic [BYTES_W-1:0] bytes;
    logic [OCC_W-1:0]   occ;
  } queue_result_t;

  entry_t        held [DEPTH];
  int            held_count;
  queue_result_t result_q [$];

  function automatic queue_result_t predict_queue_op(logic op, entry_t fresh);
    queue_result_t r;
    int            pos;
    int            i;
    r = '0;
    if (op == OP_PUSH) begin
      if (held_count >= DEPTH) begin
        r.status = ST_DROPPED;
      end else begin
        if (fresh.bytes > MAX_BYTES) fresh.bytes = BYTES_W'(MAX_BYTES);
        pos = 0;
        // stable insert: behind every entry of equal or lower priority
        while (pos < held_count && held[pos].prio <= fresh.prio) pos++;
        for (i = held_count; i > pos; i--) held[i] = held[i-1];
        held[pos] = fresh;
        held_count++;
        r.status = ST_PUSHED;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_POP_EMPTY;
      end else begin
        r.prio  = held[0].prio;
        r.id    = held[0].id;
        r.bytes = held[0].bytes;
        for (i = 1; i < held_count; i++) held[i-1] = held[i];
        held_count--;
        r.status = ST_POPPED;
      end
    end
    r.occ = OCC_W'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    entry_t        fresh;
    queue_result_t want;
    queue_result_t got;
    if (!rst_n) begin
      held_count = 0;
      result_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        fresh = {in_priority_req, in_work_id, in_byte_count};
        result_q.push_back(predict_queue_op(in_operation, fresh));
      end
      if (out_valid && !out_stall) begin
        got.status = status_t'(out_status);
        got.prio   = out_priority;
        got.id     = out_work_id;
        got.bytes  = out_byte_count;
        got.occ    = out_occupancy;
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected result transaction status=%0d occ=%0d",
                     out_status, out_occupancy);
        end else begin
          want = result_q.pop_front();
          checked++;
          if (want.status == ST_DROPPED) drops++;
          if (want.status == ST_POP_EMPTY) empty_pops++;
          if (got.status !== want.status || got.prio !== want.prio ||
              got.id !== want.id || got.bytes !== want.bytes ||
              got.occ !== want.occ) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("ERROR: result %0d expected st=%0d prio=%h id=%h bytes=%h occ=%0d",
                       checked, want.status, want.prio, want.id, want.bytes, want.occ);
              $display("       got                st=%0d prio=%h id=%h bytes=%h occ=%0d",
                       out_status, out_priority, out_work_id, out_byte_count,
                       out_occupancy);
            end
          end
        end
      end
    end
    pending = result_q.size();
  end

endmodule

@@ test/tb_stable_min_priority_queue.sv @@
// ----------------------------------------------------------------------------
// tb_stable_min_priority_queue
// Drives push and pop transactions into the stable minimum priority queue
// with random idle and stall bursts. A directed opening covers the extremes,
// equal priorities, saturating byte counts, a full queue and an empty queue.
// Random phases then swing the occupancy between empty and full. The
// checker does the prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_stable_min_priority_queue;
  import smpq_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_operation;
  logic [PRIO_W-1:0]  in_priority_req;
  logic [ID_W-1:0]    in_work_id;
  logic [BYTES_W-1:0] in_byte_count;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [PRIO_W-1:0]  out_priority;
  logic [ID_W-1:0]    out_work_id;
  logic [BYTES_W-1:0] out_byte_count;
  logic [OCC_W-1:0]   out_occupancy;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned drops;
  int unsigned empty_pops;

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned push_pct  = 50;
  bit          quiet     = 1'b0;
  int unsigned stall_left = 0;
  int unsigned n_sent    = 0;

  stable_min_priority_queue dut (.*);
  smpq_checker u_checker (.*);

  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
      if (!quiet && rst_n && $urandom_range(0, 99) < stall_pct)
        stall_left = $urandom_range(1, 3);
    end
  end

  task automatic send_item(input logic op, input logic [PRIO_W-1:0] prio,
                           input logic [ID_W-1:0] id, input logic [BYTES_W-1:0] bytes);
    int unsigned gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 3);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_operation    = op;
    in_priority_req = prio;
    in_work_id      = id;
    in_byte_count   = bytes;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  function automatic logic [PRIO_W-1:0] rand_prio();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return PRIO_W'($urandom_range(0, 7));
      5:       return PRIO_W'($urandom_range(16'hFFF8, 16'hFFFF));
      default: return PRIO_W'($urandom());
    endcase
  endfunction

  function automatic logic [BYTES_W-1:0] rand_bytes();
    case ($urandom_range(0, 9))
      0:       return BYTES_W'(MAX_BYTES);
      1:       return BYTES_W'(MAX_BYTES + 1);
      2, 3:    return BYTES_W'($urandom());
      default: return BYTES_W'($urandom_range(0, MAX_BYTES));
    endcase
  endfunction

  initial begin
    int unsigned n_directed;
    int          ph;
    int          k;
    logic        op;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_PUSH;
    in_priority_req = '0;
    in_work_id      = '0;
    in_byte_count   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty pop with junk push fields, extremes, ties, saturation
    send_item(OP_POP, '1, '1, '1);
    send_item(OP_PUSH, 16'h8000, 16'h0001, BYTES_W'(MAX_BYTES));
    send_item(OP_PUSH, '1, '1, '1);
    send_item(OP_PUSH, '0, '0, '0);
    send_item(OP_PUSH, 16'h8000, 16'h0002, BYTES_W'(MAX_BYTES + 1));
    send_item(OP_PUSH, '0, '1, 21'd1);
    send_item(OP_POP, '0, '0, '0);
    send_item(OP_PUSH, '1, 16'h1234, rand_bytes());
    for (k = 0; k < 11; k++)
      send_item(OP_PUSH, (k % 3 == 0) ? 16'h0000 : (k % 3 == 1) ? 16'h8000 : 16'hFFFF,
                ID_W'(k + 16'h0100), BYTES_W'($urandom_range(0, MAX_BYTES)));
    // queue is full here
    send_item(OP_PUSH, '0, '1, '1);
    send_item(OP_PUSH, '1, '0, '0);
    for (k = 0; k < 4; k++)
      send_item(OP_POP, PRIO_W'($urandom()), ID_W'($urandom()), BYTES_W'($urandom()));
    n_directed = n_sent;

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: push_pct = 90;
        1: push_pct = 50;
        2: push_pct = 15;
        3: push_pct = 95;
        4: push_pct = 60;
        5: push_pct = 30;
        6: push_pct = 85;
        7: push_pct = 50;
        8: push_pct = 10;
        default: push_pct = 55;
      endcase
      if (ph == 0 || ph == 5) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(10, 40);
        stall_pct = $urandom_range(10, 40);
      end
      quiet = (ph == 9);
      for (k = 0; k < 103; k++) begin
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        send_item(op, rand_prio(), ID_W'($urandom()), rand_bytes());
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);

    $display("Covered %0d transactions (%0d directed), %0d results checked",
             n_sent, n_directed, checked);
    $display("Saw %0d pushes dropped on a full queue and %0d pops on an empty queue",
             drops, empty_pops);
    if (fail_count == 0) begin
      $display("PASS stable_min_priority_queue");
    end else begin
      $display("FAIL stable_min_priority_queue");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL stable_min_priority_queue");
    $finish;
  end

endmodule
